// ===== rtl/pli_pkg.sv =====
// pli_pkg: shared types, codes and defaults for the piecewise linear interpolator
// no dependencies; imported by pli_ctrl, pli_dp and piecewise_linear_interpolator
package pli_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 256;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic               command;
    logic        [7:0]  entry_index;
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;
  } pli_in_t;

  typedef struct packed {
    logic signed [31:0] y_result;
    logic               saturated;
  } pli_out_t;

  typedef enum logic [2:0] {
    ADDR_ZERO,
    ADDR_LAST,
    ADDR_MID,
    ADDR_N0,
    ADDR_N1
  } addr_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_F0_A,
    ST_F0_U,
    ST_L_A,
    ST_L_U,
    ST_S_A,
    ST_S_U,
    ST_S_END,
    ST_P0_A,
    ST_P0_U,
    ST_P1_A,
    ST_P1_U,
    ST_MUL,
    ST_DIV,
    ST_FIN,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic      load_wr;
    logic      start;
    addr_sel_t addr_sel;
    logic      first_u;
    logic      last_u;
    logic      srch_u;
    logic      seg_end;
    logic      p0_u;
    logic      p1_u;
    logic      mul;
    logic      div_step;
    logic      fin;
    logic      ret_y0;
    logic      out_load;
  } pli_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic q_lt_x;
    logic cnt_zero;
    logic q_eq_x;
    logic n1_none;
    logic x_eq_x0;
    logic div_last;
  } pli_sts_t;

endpackage

// ===== rtl/piecewise_linear_interpolator.sv =====
// piecewise linear interpolator over a table of signed q16.16 points
// sequence: a load word is written when accepted; a query raises out_valid after its table reads
//   when it returns a table y, or after search reads, a multiply and a 64-step divider when it divides
// throughput: one word in flight; the next word can be taken as out_valid rises, and a result
//   still held in the output register stalls the next query in its final state
// reset: rst_n synchronous active low; points in use returns to 1, tables are not cleared
module piecewise_linear_interpolator
  import pli_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  // input words: loads and queries
  input  logic       in_valid,
  output logic       in_ready,
  input  pli_in_t    in_word,
  // result words, one per query
  output logic       out_valid,
  input  logic       out_ready,
  output pli_out_t   out_word,
  // points in use register
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [8:0] cfg_data
);

  pli_cmd_t cmd;
  pli_sts_t sts;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  // sequencer: walks search, multiply, divide, and holds the output valid
  pli_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_is_query (in_word.command == CMD_QUERY),
    .in_ready    (in_ready),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .cmd         (cmd),
    .sts         (sts)
  );

  // tables, arithmetic and the output word register
  pli_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .in_word  (in_word),
    .out_word (out_word),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule

// ===== rtl/pli_ctrl.sv =====
// pli_ctrl: sequencer for table loads, the binary search, multiply and divide
// depends on pli_pkg
module pli_ctrl
  import pli_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_is_query,
  output logic     in_ready,
  input  logic     out_ready,
  output logic     out_valid,
  output pli_cmd_t cmd,
  input  pli_sts_t sts
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_fire;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.addr_sel  = ADDR_ZERO;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_is_query) begin
            cmd.start = 1'b1;
            state_nxt = ST_F0_A;
          end else begin
            cmd.load_wr = 1'b1;
          end
        end
      end
      ST_F0_A: begin
        cmd.addr_sel = ADDR_ZERO;
        state_nxt    = ST_F0_U;
      end
      ST_F0_U: begin
        cmd.first_u = 1'b1;
        state_nxt   = sts.q_lt_x ? ST_P0_A : ST_L_A;
      end
      ST_L_A: begin
        cmd.addr_sel = ADDR_LAST;
        state_nxt    = ST_L_U;
      end
      ST_L_U: begin
        cmd.last_u = 1'b1;
        state_nxt  = sts.q_lt_x ? ST_S_A : ST_P0_A;
      end
      ST_S_A: begin
        cmd.addr_sel = ADDR_MID;
        state_nxt    = sts.cnt_zero ? ST_S_END : ST_S_U;
      end
      ST_S_U: begin
        cmd.srch_u = 1'b1;
        state_nxt  = ST_S_A;
      end
      ST_S_END: begin
        cmd.seg_end = 1'b1;
        state_nxt   = ST_P0_A;
      end
      ST_P0_A: begin
        cmd.addr_sel = ADDR_N0;
        state_nxt    = ST_P0_U;
      end
      ST_P0_U: begin
        cmd.p0_u = 1'b1;
        if (sts.q_eq_x || sts.n1_none) begin
          cmd.ret_y0 = 1'b1;
          state_nxt  = ST_DONE;
        end else begin
          state_nxt = ST_P1_A;
        end
      end
      ST_P1_A: begin
        cmd.addr_sel = ADDR_N1;
        state_nxt    = ST_P1_U;
      end
      ST_P1_U: begin
        cmd.p1_u = 1'b1;
        if (sts.x_eq_x0) begin
          cmd.ret_y0 = 1'b1;
          state_nxt  = ST_DONE;
        end else begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_query_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_is_query |=> state_r == ST_F0_A)
    else $error("query did not start the search");
  a_div_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV && sts.div_last |=> state_r == ST_FIN)
    else $error("divider end not followed by finish");
  a_done_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r && state_r == ST_IDLE)
    else $error("finished word not presented");
`endif

endmodule

// ===== rtl/pli_dp.sv =====
// pli_dp: point tables, search registers, multiplier, restoring divider, output word
// depends on pli_pkg
module pli_dp
  import pli_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr,
  input  logic [8:0] cfg_data,
  input  pli_in_t    in_word,
  output pli_out_t   out_word,
  input  pli_cmd_t   cmd,
  output pli_sts_t   sts
);

  localparam int unsigned AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  logic [31:0] mem_x [TABLE_DEPTH];
  logic [31:0] mem_y [TABLE_DEPTH];

  logic [8:0]         points_r;
  logic signed [31:0] q_r, x0_r, y0_r, rd_x, rd_y;
  logic [CNT_W-1:0]   n_r, lo_r, cnt_r;
  logic [AW-1:0]      n0_r, n1_r;
  logic [31:0]        mdy_r, mdq_r, mdx_r;
  logic               neg_r;
  logic [63:0]        dvd_r;
  logic [31:0]        rem_r;
  logic [5:0]         dcnt_r;
  logic signed [31:0] res_r;
  logic               sat_r;
  pli_out_t           out_r;

  logic [31:0]        idx_ext, pu_ext, n_calc;
  logic               wr_ok;
  logic [AW-1:0]      rd_addr;
  logic [CNT_W-1:0]   step, mid;
  logic [CNT_W:0]     n0_inc;
  logic signed [32:0] dy, dq, dx;
  logic [32:0]        trial;
  logic               ge;
  logic               ng;
  logic signed [34:0] sum;

  assign idx_ext = 32'(in_word.entry_index);
  assign wr_ok   = idx_ext < TABLE_DEPTH;
  assign pu_ext  = 32'(points_r);
  assign n_calc  = (pu_ext == 32'd0) ? 32'd1 :
                   (pu_ext > TABLE_DEPTH) ? 32'(TABLE_DEPTH) : pu_ext;
  assign step    = cnt_r >> 1;
  assign mid     = lo_r + step;
  assign n0_inc  = (CNT_W + 1)'(n0_r) + (CNT_W + 1)'(1);

  always_comb begin
    case (cmd.addr_sel)
      ADDR_ZERO: rd_addr = '0;
      ADDR_LAST: rd_addr = AW'(n_r - CNT_W'(1));
      ADDR_MID:  rd_addr = AW'(mid);
      ADDR_N0:   rd_addr = n0_r;
      ADDR_N1:   rd_addr = n1_r;
      default:   rd_addr = '0;
    endcase
  end

  // table write on load, registered read for the sequencer
  always_ff @(posedge clk) begin
    if (cmd.load_wr && wr_ok) begin
      mem_x[idx_ext[AW-1:0]] <= in_word.x_value;
      mem_y[idx_ext[AW-1:0]] <= in_word.y_value;
    end
    rd_x <= mem_x[rd_addr];
    rd_y <= mem_y[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      points_r <= 9'd1;
    end else if (cfg_wr) begin
      points_r <= cfg_data;
    end
  end

  assign dy    = 33'(rd_y) - 33'(y0_r);
  assign dq    = 33'(q_r) - 33'(x0_r);
  assign dx    = 33'(rd_x) - 33'(x0_r);
  assign trial = {rem_r, dvd_r[63]};
  assign ge    = trial >= {1'b0, mdx_r};
  assign ng    = neg_r && (dvd_r != 64'd0);
  assign sum   = ng ? (35'(y0_r) - $signed({1'b0, dvd_r[33:0]}))
                    : (35'(y0_r) + $signed({1'b0, dvd_r[33:0]}));

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      q_r <= in_word.x_value;
      n_r <= CNT_W'(n_calc);
    end
    if (cmd.first_u && sts.q_lt_x) begin
      n0_r <= '0;
    end
    if (cmd.last_u) begin
      if (!sts.q_lt_x) begin
        n0_r <= AW'(n_r - CNT_W'(1));
      end
      lo_r  <= '0;
      cnt_r <= n_r;
    end
    if (cmd.srch_u) begin
      if (!sts.q_lt_x) begin
        lo_r  <= mid + CNT_W'(1);
        cnt_r <= cnt_r - step - CNT_W'(1);
      end else begin
        cnt_r <= step;
      end
    end
    if (cmd.seg_end) begin
      n0_r <= (lo_r == '0) ? '0 : AW'(lo_r - CNT_W'(1));
    end
    if (cmd.p0_u) begin
      x0_r <= rd_x;
      y0_r <= rd_y;
      n1_r <= (n0_inc >= (CNT_W + 1)'(n_r)) ? AW'(n0_r - AW'(1)) : AW'(n0_inc);
    end
    if (cmd.p1_u) begin
      mdy_r <= dy[32] ? 32'(-dy) : dy[31:0];
      mdq_r <= dq[32] ? 32'(-dq) : dq[31:0];
      mdx_r <= dx[32] ? 32'(-dx) : dx[31:0];
      neg_r <= dy[32] ^ dq[32] ^ dx[32];
    end
    if (cmd.mul) begin
      dvd_r  <= 64'(mdy_r) * 64'(mdq_r);
      rem_r  <= '0;
      dcnt_r <= '0;
    end
    // one quotient bit per cycle
    if (cmd.div_step) begin
      rem_r  <= ge ? 32'(trial - {1'b0, mdx_r}) : trial[31:0];
      dvd_r  <= {dvd_r[62:0], ge};
      dcnt_r <= dcnt_r + 6'd1;
    end
    if (cmd.ret_y0) begin
      res_r <= cmd.p0_u ? rd_y : y0_r;
      sat_r <= 1'b0;
    end
    if (cmd.fin) begin
      if (dvd_r > (64'd1 << 33)) begin
        res_r <= ng ? 32'sh8000_0000 : 32'sh7fff_ffff;
        sat_r <= 1'b1;
      end else if (sum > 35'sh0_7fff_ffff) begin
        res_r <= 32'sh7fff_ffff;
        sat_r <= 1'b1;
      end else if (sum < -35'sh0_8000_0000) begin
        res_r <= 32'sh8000_0000;
        sat_r <= 1'b1;
      end else begin
        res_r <= sum[31:0];
        sat_r <= 1'b0;
      end
    end
    if (cmd.out_load) begin
      out_r.y_result  <= res_r;
      out_r.saturated <= sat_r;
    end
  end

  assign out_word     = out_r;
  assign sts.q_lt_x   = q_r < rd_x;
  assign sts.cnt_zero = (cnt_r == '0);
  assign sts.q_eq_x   = (q_r == rd_x);
  assign sts.n1_none  = (n0_inc >= (CNT_W + 1)'(n_r)) && (n0_r == '0);
  assign sts.x_eq_x0  = (rd_x == x0_r);
  assign sts.div_last = (dcnt_r == 6'd63);

endmodule
